// ===== rtl/spise_pkg.sv =====
// shared types and constants for the spi master shift engine
`default_nettype none
package spise_pkg;

	// register access codes carried with each tick
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_BAUD   = 3'd0;
	localparam logic [2:0] REG_CPOL   = 3'd1;
	localparam logic [2:0] REG_CPHA   = 3'd2;
	localparam logic [2:0] REG_WIDE   = 3'd3;
	localparam logic [2:0] REG_LSBF   = 3'd4;
	localparam logic [2:0] REG_TXONLY = 3'd5;

	// configuration registers
	typedef struct packed {
		logic [2:0] baud;
		logic       cpol;
		logic       cpha;
		logic       wide;
		logic       lsbf;
		logic       txonly;
	} cfg_t;

	// engine state carried from tick to tick
	typedef struct packed {
		logic [15:0] tx_buf;
		logic        tx_full;
		logic [15:0] shift;
		logic [4:0]  bits_left;
		logic [7:0]  presc;
		logic        sck;
		logic [15:0] rx_buf;
		logic        rx_full;
		logic        smp;
	} state_t;

	// one result beat
	typedef struct packed {
		logic        busy;
		logic        rxne;
		logic        txe;
		logic [15:0] rx_word;
		logic        mosi;
		logic        sck;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/spi_master_shift_engine.sv =====
// spi master shift engine top level: config registers, tick state and output register
//
// Each input beat is one peripheral clock tick. tuser carries the register access
// code (tick, data write, data read); tdata carries the word to write and the MISO
// level. Every accepted beat yields exactly one output beat with the SCK and MOSI
// levels, the receive buffer and the TXE, RXNE and BSY flags after that tick.
// SCK toggles every 2^baud_code ticks while a frame shifts, giving PCLK/2^(code+1).
// The result of a beat is registered and is on the master side the cycle after it
// is accepted. Throughput is one beat per cycle unless the output stalls, set by
// the single state register that closes the tick loop through the next-state logic.
// Configuration is written through the cfg port, one register per write, by the user
// only while the stream is idle; the block does not enforce it. Reset clears all
// buffers and flags and parks SCK low. When the receiver stalls, the output register
// holds its beat and the slave side takes a new beat only as the held one leaves.
`default_nettype none
module spi_master_shift_engine (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [2:0]  cfg_wdata,
	// tick stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // tx_word[15:0], miso_level[16], zero pad
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	// result stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sck_level[0], mosi_level[1], rx_word[17:2], tx_empty[18], rx_not_empty[19],
	// busy_res[20], zero pad
	output logic [23:0] m_axis_tdata
);
	import spise_pkg::*;

	cfg_t        cfg_q;
	state_t      state_q;
	state_t      state_nxt;
	res_t        res;
	res_t        res_q;
	logic        out_valid_q;
	logic        accept;

	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign accept        = s_axis_tvalid & s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BAUD:   cfg_q.baud   <= cfg_wdata;
				REG_CPOL:   cfg_q.cpol   <= cfg_wdata[0];
				REG_CPHA:   cfg_q.cpha   <= cfg_wdata[0];
				REG_WIDE:   cfg_q.wide   <= cfg_wdata[0];
				REG_LSBF:   cfg_q.lsbf   <= cfg_wdata[0];
				REG_TXONLY: cfg_q.txonly <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// one tick of next-state logic
	spise_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.func    (s_axis_tuser),
		.tx_word (s_axis_tdata[15:0]),
		.miso    (s_axis_tdata[16]),
		.nxt     (state_nxt),
		.res     (res)
	);

	// engine state advances on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q};

endmodule
`default_nettype wire

// ===== rtl/spise_step.sv =====
// next-state and result logic for one peripheral clock tick
`default_nettype none
module spise_step (
	input  spise_pkg::cfg_t   cfg,
	input  spise_pkg::state_t cur,
	input  logic [1:0]        func,
	input  logic [15:0]       tx_word,
	input  logic              miso,
	output spise_pkg::state_t nxt,
	output spise_pkg::res_t   res
);
	import spise_pkg::*;

	// shift one bit into the frame, direction set by the bit order
	function automatic logic [15:0] shift_in(input logic [15:0] sw, input logic b,
			input logic wide, input logic lsbf);
		logic [15:0] r;
		if (lsbf) begin
			if (wide) begin
				r = {b, sw[15:1]};
			end else begin
				r = {8'h00, b, sw[7:1]};
			end
		end else begin
			if (wide) begin
				r = {sw[14:0], b};
			end else begin
				r = {8'h00, sw[6:0], b};
			end
		end
		return r;
	endfunction

	logic [7:0]  pc_inc;
	logic [7:0]  half;
	logic        leading;
	logic [4:0]  fbits;
	logic [15:0] mask;
	logic [4:0]  bl_dec;

	assign pc_inc  = cur.presc + 8'd1;
	assign half    = 8'd1 << cfg.baud;
	assign leading = (cur.sck == cfg.cpol);
	assign fbits   = cfg.wide ? 5'd16 : 5'd8;
	assign mask    = cfg.wide ? 16'hFFFF : 16'h00FF;
	assign bl_dec  = cur.bits_left - 5'd1;

	// shift engine, then the register access of this tick
	always_comb begin
		nxt = cur;
		if (cur.bits_left == 5'd0) begin
			nxt.sck = cfg.cpol;
			if (cur.tx_full) begin
				nxt.shift     = cur.tx_buf & mask;
				nxt.bits_left = fbits;
				nxt.tx_full   = 1'b0;
				nxt.presc     = 8'd0;
			end
		end else begin
			nxt.presc = pc_inc;
			if (pc_inc >= half) begin
				nxt.presc = 8'd0;
				nxt.sck   = ~cur.sck;
				if (leading) begin
					if (!cfg.cpha) begin
						nxt.smp = miso;
					end else if (cur.bits_left < fbits) begin
						nxt.shift = shift_in(cur.shift, cur.smp, cfg.wide, cfg.lsbf);
					end
				end else begin
					if (!cfg.cpha) begin
						nxt.shift = shift_in(cur.shift, cur.smp, cfg.wide, cfg.lsbf);
					end else if (cur.bits_left == 5'd1) begin
						nxt.shift = shift_in(cur.shift, miso, cfg.wide, cfg.lsbf);
					end else begin
						nxt.smp = miso;
					end
					nxt.bits_left = bl_dec;
					if (bl_dec == 5'd0 && !cfg.txonly) begin
						nxt.rx_buf  = nxt.shift & mask;
						nxt.rx_full = 1'b1;
					end
				end
			end
		end

		// data register access
		if (func == FUNC_WRITE && !nxt.tx_full) begin
			nxt.tx_buf  = tx_word & mask;
			nxt.tx_full = 1'b1;
		end else if (func == FUNC_READ) begin
			nxt.rx_full = 1'b0;
		end
		if (cfg.txonly) begin
			nxt.rx_full = 1'b0;
		end
	end

	// result fields from the state after the tick
	always_comb begin
		res.sck     = nxt.sck;
		res.mosi    = 1'b0;
		if (nxt.bits_left != 5'd0) begin
			if (cfg.lsbf) begin
				res.mosi = nxt.shift[0];
			end else begin
				res.mosi = cfg.wide ? nxt.shift[15] : nxt.shift[7];
			end
		end
		res.rx_word = nxt.rx_buf;
		res.txe     = ~nxt.tx_full;
		res.rxne    = nxt.rx_full;
		res.busy    = (nxt.bits_left != 5'd0) || nxt.tx_full;
	end

endmodule
`default_nettype wire
